// ===== design/css_pkg.sv =====
// Shared types, register codes and reset values of the colour spill suppressor.
package css_pkg;

   localparam int SAMPLE_W = 16;
   localparam int GAIN_W   = 14;
   localparam int WORD_W   = 4 * SAMPLE_W;
   localparam int INDEX_W  = 3;
   localparam int AMOUNT_W = 34;
   localparam int PROD_W   = GAIN_W + 32;

   localparam logic [GAIN_W-1:0] UNIT_GAIN = 14'd4096;

   typedef enum logic [1:0] {
      CH_PASS  = 2'd0,
      CH_RED   = 2'd1,
      CH_GREEN = 2'd2,
      CH_BLUE  = 2'd3
   } spill_type;

   typedef enum logic [0:0] {
      MODE_SIMPLE  = 1'b0,
      MODE_AVERAGE = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      LIM_RED   = 2'd0,
      LIM_GREEN = 2'd1,
      LIM_BLUE  = 2'd2,
      LIM_ALPHA = 2'd3
   } limit_type;

   typedef enum logic [INDEX_W-1:0] {
      REG_SPILL_CHANNEL  = 3'd0,
      REG_LIMIT_MODE     = 3'd1,
      REG_LIMIT_CHANNEL  = 3'd2,
      REG_LIMIT_SCALE    = 3'd3,
      REG_UNSPILL_ENABLE = 3'd4,
      REG_WEIGHT_RED     = 3'd5,
      REG_WEIGHT_GREEN   = 3'd6,
      REG_WEIGHT_BLUE    = 3'd7
   } reg_index_type;

   typedef struct packed {
      spill_type          spill_channel;
      mode_type           limit_mode;
      limit_type          limit_channel;
      logic [GAIN_W-1:0]  limit_scale;
      logic               unspill_enable;
      logic [GAIN_W-1:0]  weight_red;
      logic [GAIN_W-1:0]  weight_green;
      logic [GAIN_W-1:0]  weight_blue;
   } cfg_type;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

endpackage

// ===== design/css_csr.sv =====
// Configuration registers of the colour spill suppressor.
module css_csr
   import css_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [INDEX_W-1:0]  csr_index,
   input  logic [GAIN_W-1:0]   csr_wdata,
   output cfg_type             cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (reg_index_type'(csr_index))
            REG_SPILL_CHANNEL:  cfg_in.spill_channel  = spill_type'(csr_wdata[1:0]);
            REG_LIMIT_MODE:     cfg_in.limit_mode     = mode_type'(csr_wdata[0]);
            REG_LIMIT_CHANNEL:  cfg_in.limit_channel  = limit_type'(csr_wdata[1:0]);
            REG_LIMIT_SCALE:    cfg_in.limit_scale    = csr_wdata;
            REG_UNSPILL_ENABLE: cfg_in.unspill_enable = csr_wdata[0];
            REG_WEIGHT_RED:     cfg_in.weight_red     = csr_wdata;
            REG_WEIGHT_GREEN:   cfg_in.weight_green   = csr_wdata;
            REG_WEIGHT_BLUE:    cfg_in.weight_blue    = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.spill_channel  <= CH_GREEN;
         cfg_ff.limit_mode     <= MODE_SIMPLE;
         cfg_ff.limit_channel  <= LIM_RED;
         cfg_ff.limit_scale    <= UNIT_GAIN;
         cfg_ff.unspill_enable <= 1'b0;
         cfg_ff.weight_red     <= '0;
         cfg_ff.weight_green   <= '0;
         cfg_ff.weight_blue    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/css_spill.sv =====
// Limit selection and spill amount stages of the colour spill suppressor.
module css_spill
   import css_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  cfg_type                     cfg,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [WORD_W-1:0]           in_word,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [WORD_W-1:0]           out_word,
   output logic signed [AMOUNT_W-1:0]  out_amount
);

   logic                       valid_a_ff, valid_a_in;
   logic [WORD_W-1:0]          word_a_ff, word_a_in;
   sample_type                 spill_a_ff, spill_a_in;
   logic signed [16:0]         term_a_ff, term_a_in;
   logic                       valid_b_ff, valid_b_in;
   logic [WORD_W-1:0]          word_b_ff, word_b_in;
   logic signed [AMOUNT_W-1:0] amount_b_ff, amount_b_in;

   logic               ready_a;
   logic               ready_b;
   sample_type         px [4];
   sample_type         lim;
   logic signed [16:0] pair;
   logic signed [31:0] prod;

   assign ready_b  = !valid_b_ff || out_ready;
   assign ready_a  = !valid_a_ff || ready_b;
   assign in_ready = ready_a;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         px[i] = sample_type'(in_word[i*SAMPLE_W +: SAMPLE_W]);
      end
      case (cfg.spill_channel)
         CH_RED: begin
            spill_a_in = px[0];
            pair       = {px[1][15], px[1]} + {px[2][15], px[2]};
         end
         CH_GREEN: begin
            spill_a_in = px[1];
            pair       = {px[0][15], px[0]} + {px[2][15], px[2]};
         end
         CH_BLUE: begin
            spill_a_in = px[2];
            pair       = {px[0][15], px[0]} + {px[1][15], px[1]};
         end
         default: begin
            spill_a_in = px[0];
            pair       = '0;
         end
      endcase
      case (cfg.limit_channel)
         LIM_RED:   lim = px[0];
         LIM_GREEN: lim = px[1];
         LIM_BLUE:  lim = px[2];
         default:   lim = px[3];
      endcase
      if (cfg.limit_mode == MODE_AVERAGE) begin
         term_a_in = pair;
      end else begin
         term_a_in = {lim, 1'b0};
      end
      word_a_in  = in_word;
      valid_a_in = ready_a ? in_valid : valid_a_ff;
   end

   always_comb begin
      prod        = 32'(signed'({1'b0, cfg.limit_scale})) * 32'(term_a_ff);
      amount_b_in = {{5{spill_a_ff[15]}}, spill_a_ff, 13'd0} - {{2{prod[31]}}, prod};
      word_b_in   = word_a_ff;
      valid_b_in  = ready_b ? valid_a_ff : valid_b_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         valid_a_ff <= valid_a_in;
         valid_b_ff <= valid_b_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_a) begin
         word_a_ff  <= word_a_in;
         spill_a_ff <= spill_a_in;
         term_a_ff  <= term_a_in;
      end
      if (ready_b) begin
         word_b_ff   <= word_b_in;
         amount_b_ff <= amount_b_in;
      end
   end

   assign out_valid  = valid_b_ff;
   assign out_word   = word_b_ff;
   assign out_amount = amount_b_ff;

endmodule

// ===== design/css_correct.sv =====
// Weighted correction, rounding and saturation stages of the colour spill suppressor.
module css_correct
   import css_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  cfg_type                     cfg,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [WORD_W-1:0]           in_word,
   input  logic signed [AMOUNT_W-1:0]  in_amount,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [WORD_W-1:0]           out_word
);

   logic              valid_c_ff, valid_c_in;
   logic [WORD_W-1:0] word_c_ff, word_c_in;
   logic [PROD_W-1:0] prod_c_ff [3];
   logic [PROD_W-1:0] prod_c_in [3];
   logic [2:0]        sub_c_ff, sub_c_in;
   logic              valid_d_ff, valid_d_in;
   logic [WORD_W-1:0] word_d_ff, word_d_in;

   logic              ready_c;
   logic              ready_d;
   logic              positive;
   logic [31:0]       mag;
   logic [GAIN_W-1:0] w [3];
   logic [PROD_W:0]   rounded;
   logic [21:0]       corr;
   logic signed [23:0] res;

   assign ready_d  = !valid_d_ff || out_ready;
   assign ready_c  = !valid_c_ff || ready_d;
   assign in_ready = ready_c;

   always_comb begin
      positive = !in_amount[AMOUNT_W-1] && (in_amount != '0)
                 && (cfg.spill_channel != CH_PASS);
      mag = positive ? in_amount[31:0] : 32'd0;
      case (cfg.spill_channel)
         CH_RED:   sub_c_in = 3'b001;
         CH_GREEN: sub_c_in = 3'b010;
         CH_BLUE:  sub_c_in = 3'b100;
         default:  sub_c_in = 3'b000;
      endcase
      if (cfg.unspill_enable) begin
         w[0] = cfg.weight_red;
         w[1] = cfg.weight_green;
         w[2] = cfg.weight_blue;
      end else begin
         for (int i = 0; i < 3; i++) begin
            w[i] = sub_c_in[i] ? UNIT_GAIN : '0;
         end
      end
      for (int i = 0; i < 3; i++) begin
         prod_c_in[i] = PROD_W'(w[i]) * PROD_W'(mag);
      end
      word_c_in  = in_word;
      valid_c_in = ready_c ? in_valid : valid_c_ff;
   end

   always_comb begin
      word_d_in = word_c_ff;
      rounded   = '0;
      corr      = '0;
      res       = '0;
      for (int i = 0; i < 3; i++) begin
         rounded = {1'b0, prod_c_ff[i]} + (PROD_W+1)'(1 << 24);
         corr    = rounded[46:25];
         res     = 24'(signed'(word_c_ff[i*SAMPLE_W +: SAMPLE_W]));
         if (sub_c_ff[i]) begin
            res = res - $signed({2'b00, corr});
         end else begin
            res = res + $signed({2'b00, corr});
         end
         if (res > 24'sd32767) begin
            word_d_in[i*SAMPLE_W +: SAMPLE_W] = 16'h7fff;
         end else if (res < -24'sd32768) begin
            word_d_in[i*SAMPLE_W +: SAMPLE_W] = 16'h8000;
         end else begin
            word_d_in[i*SAMPLE_W +: SAMPLE_W] = res[15:0];
         end
      end
      valid_d_in = ready_d ? valid_c_ff : valid_d_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_c_ff <= 1'b0;
         valid_d_ff <= 1'b0;
      end else begin
         valid_c_ff <= valid_c_in;
         valid_d_ff <= valid_d_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_c) begin
         word_c_ff <= word_c_in;
         sub_c_ff  <= sub_c_in;
         for (int i = 0; i < 3; i++) begin
            prod_c_ff[i] <= prod_c_in[i];
         end
      end
      if (ready_d) begin
         word_d_ff <= word_d_in;
      end
   end

   assign out_valid = valid_d_ff;
   assign out_word  = word_d_ff;

endmodule

// ===== design/color_spill_suppressor.sv =====
// Top level of the colour spill suppressor: one RGBA pixel word in, one corrected word out.
//
//   channel  direction  handshake         payload
//   req      in         tvalid / tready   tdata: red, green, blue, alpha
//   rsp      out        tvalid / tready   tdata: red, green, blue, alpha
//   csr      in         csr_we            csr_index, csr_wdata
//
// A word passes four register stages: limit select, amount multiply, weight multiply,
// round and saturate. A word reaches the output register through these stages in that order.
// One word is accepted each cycle unless a stalled output has filled the stages.
// Reset returns the registers to their defaults and empties the pipeline.
// A stalled output holds its stage; upstream stages keep filling until they are full.
module color_spill_suppressor
   import css_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [WORD_W-1:0]   req_tdata,   // red_in, green_in, blue_in, alpha_in
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [WORD_W-1:0]   rsp_tdata,   // red_out, green_out, blue_out, alpha_out
   input  logic                csr_we,
   input  logic [INDEX_W-1:0]  csr_index,
   input  logic [GAIN_W-1:0]   csr_wdata
);

   cfg_type                    cfg;
   logic                       mid_valid;
   logic                       mid_ready;
   logic [WORD_W-1:0]          mid_word;
   logic signed [AMOUNT_W-1:0] mid_amount;

   css_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   css_spill u_spill (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_word    (req_tdata),
      .out_valid  (mid_valid),
      .out_ready  (mid_ready),
      .out_word   (mid_word),
      .out_amount (mid_amount)
   );

   css_correct u_correct (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_word   (mid_word),
      .in_amount (mid_amount),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_word  (rsp_tdata)
   );

endmodule

// ===== tb/color_spill_suppressor_test.sv =====
// Self-checking testbench of the colour spill suppressor, with random register settings and pixels.
module color_spill_suppressor_test;
   import css_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_PIXELS  = 125;
   localparam int SETTLE_CYCLES = 8;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [WORD_W-1:0]   req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [WORD_W-1:0]   rsp_tdata;
   logic                csr_we = 1'b0;
   logic [INDEX_W-1:0]  csr_index = '0;
   logic [GAIN_W-1:0]   csr_wdata = '0;

   logic [WORD_W-1:0]   pixels_to_send [$];
   logic [WORD_W-1:0]   expected_pixels [$];
   logic [WORD_W-1:0]   wanted_pixel;
   cfg_type             settings;
   logic                req_fire = 1'b0;
   bit                  quiet = 1'b0;
   int                  send_gap = 0;
   int                  stall_left = 0;
   int                  error_count = 0;
   int                  pixels_checked = 0;
   int                  settings_applied = 0;
   int                  cycle_count = 0;
   string               channel_names [4] = '{"red", "green", "blue", "alpha"};

   color_spill_suppressor u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic sample_type saturate_sample(longint value);
      if (value > 32767) begin
         return 16'sh7FFF;
      end
      if (value < -32768) begin
         return 16'sh8000;
      end
      return sample_type'(value);
   endfunction

   function automatic logic [WORD_W-1:0] corrected_pixel(cfg_type c, logic [WORD_W-1:0] word);
      longint            px [4];
      longint            res [3];
      logic [GAIN_W-1:0] w [3];
      longint            amount;
      longint            pair;
      longint            corr;
      int                s;
      for (int i = 0; i < 4; i++) begin
         px[i] = sample_type'(word[i*SAMPLE_W +: SAMPLE_W]);
      end
      for (int i = 0; i < 3; i++) begin
         res[i] = px[i];
      end
      if (c.spill_channel != CH_PASS) begin
         s = int'(c.spill_channel) - 1;
         if (c.limit_mode == MODE_SIMPLE) begin
            amount = px[s] * 8192 - longint'(c.limit_scale) * 2 * px[int'(c.limit_channel)];
         end else begin
            pair = 0;
            for (int i = 0; i < 3; i++) begin
               if (i != s) begin
                  pair += px[i];
               end
            end
            amount = px[s] * 8192 - longint'(c.limit_scale) * pair;
         end
         if (c.unspill_enable) begin
            w[0] = c.weight_red;
            w[1] = c.weight_green;
            w[2] = c.weight_blue;
         end else begin
            w[0] = '0;
            w[1] = '0;
            w[2] = '0;
            w[s] = UNIT_GAIN;
         end
         if (amount > 0) begin
            for (int i = 0; i < 3; i++) begin
               corr = (longint'(w[i]) * amount + 64'sd16777216) >>> 25;
               if (i == s) begin
                  res[i] -= corr;
               end else begin
                  res[i] += corr;
               end
            end
         end
      end
      return {word[3*SAMPLE_W +: SAMPLE_W], saturate_sample(res[2]), saturate_sample(res[1]),
              saturate_sample(res[0])};
   endfunction

   function automatic logic [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0: return 16'h8000;
               1: return 16'h7FFF;
               2: return 16'h0000;
               default: return 16'hFFFF;
            endcase
         end
         1, 2, 3: return 16'($urandom_range(0, 8192));
         4: return 16'($urandom_range(0, 1024)) - 16'd512;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [WORD_W-1:0] random_pixel();
      return {random_sample(), random_sample(), random_sample(), random_sample()};
   endfunction

   function automatic logic [GAIN_W-1:0] random_gain();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return 14'h3FFF;
         2: return UNIT_GAIN;
         3: return 14'($urandom_range(3000, 5000));
         default: return 14'($urandom);
      endcase
   endfunction

   function automatic cfg_type random_settings();
      cfg_type c;
      c.spill_channel  = spill_type'(($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3));
      c.limit_mode     = mode_type'($urandom_range(0, 1));
      c.limit_channel  = limit_type'($urandom_range(0, 3));
      c.limit_scale    = random_gain();
      c.unspill_enable = 1'($urandom_range(0, 1));
      c.weight_red     = random_gain();
      c.weight_green   = random_gain();
      c.weight_blue    = random_gain();
      return c;
   endfunction

   task automatic write_register(reg_index_type index, logic [GAIN_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
   endtask

   // Narrow registers may be written with junk in the upper bits, which they must ignore.
   task automatic apply_settings(cfg_type c);
      logic [GAIN_W-1:0] junk;
      junk = ($urandom_range(0, 1) == 1) ? 14'($urandom) : '0;
      write_register(REG_SPILL_CHANNEL, (junk & ~14'h3) | 14'(c.spill_channel));
      write_register(REG_LIMIT_MODE, (junk & ~14'h1) | 14'(c.limit_mode));
      write_register(REG_LIMIT_CHANNEL, (junk & ~14'h3) | 14'(c.limit_channel));
      write_register(REG_LIMIT_SCALE, c.limit_scale);
      write_register(REG_UNSPILL_ENABLE, (junk & ~14'h1) | 14'(c.unspill_enable));
      write_register(REG_WEIGHT_RED, c.weight_red);
      write_register(REG_WEIGHT_GREEN, c.weight_green);
      write_register(REG_WEIGHT_BLUE, c.weight_blue);
      @(negedge clock);
      csr_we <= 1'b0;
      settings = c;
      settings_applied++;
   endtask

   task automatic wait_until_drained();
      while (pixels_to_send.size() != 0 || expected_pixels.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic queue_directed_pixels();
      pixels_to_send.push_back(64'h0000_0000_0000_0000);
      pixels_to_send.push_back(64'h7FFF_8000_7FFF_8000);
      pixels_to_send.push_back(64'h8000_7FFF_7FFF_7FFF);
      pixels_to_send.push_back(64'h8000_8000_8000_8000);
      pixels_to_send.push_back(64'h1000_0800_1800_1000);
      pixels_to_send.push_back(64'hC000_0FFF_1001_1000);
   endtask

   always @(posedge clock) begin
      req_fire <= !reset && req_tvalid && req_tready;
   end

   always @(negedge clock) begin
      if (req_fire) begin
         expected_pixels.push_back(corrected_pixel(settings, pixels_to_send.pop_front()));
         if (!quiet && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(1, 18);
         end
      end
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_fire) begin
         req_tvalid <= 1'b1;
      end else if (send_gap > 0) begin
         send_gap--;
         req_tvalid <= 1'b0;
      end else if (pixels_to_send.size() != 0) begin
         req_tvalid <= 1'b1;
         req_tdata  <= pixels_to_send[0];
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 17);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_pixels.size() == 0) begin
            $display("%0t: unexpected word %h with no pixel outstanding", $time, rsp_tdata);
            error_count++;
         end else begin
            wanted_pixel = expected_pixels.pop_front();
            pixels_checked++;
            for (int k = 0; k < 4; k++) begin
               if (rsp_tdata[k*SAMPLE_W +: SAMPLE_W] !== wanted_pixel[k*SAMPLE_W +: SAMPLE_W]) begin
                  $display("%0t: %s expected %0d, actual %0d", $time, channel_names[k],
                           sample_type'(wanted_pixel[k*SAMPLE_W +: SAMPLE_W]),
                           sample_type'(rsp_tdata[k*SAMPLE_W +: SAMPLE_W]));
                  error_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles with %0d words outstanding.", cycle_count,
                  expected_pixels.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      cfg_type c;
      settings.spill_channel  = CH_GREEN;
      settings.limit_mode     = MODE_SIMPLE;
      settings.limit_channel  = LIM_RED;
      settings.limit_scale    = UNIT_GAIN;
      settings.unspill_enable = 1'b0;
      settings.weight_red     = '0;
      settings.weight_green   = '0;
      settings.weight_blue    = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // The reset values are checked first, before any register is written.
      queue_directed_pixels();
      wait_until_drained();

      c = random_settings();
      c.spill_channel = CH_PASS;
      apply_settings(c);
      queue_directed_pixels();
      wait_until_drained();

      c.spill_channel  = CH_BLUE;
      c.limit_mode     = MODE_SIMPLE;
      c.limit_channel  = LIM_ALPHA;
      c.limit_scale    = 14'h3FFF;
      c.unspill_enable = 1'b1;
      c.weight_red     = 14'h3FFF;
      c.weight_green   = 14'h3FFF;
      c.weight_blue    = 14'h3FFF;
      apply_settings(c);
      queue_directed_pixels();
      wait_until_drained();

      c.spill_channel  = CH_RED;
      c.limit_mode     = MODE_AVERAGE;
      c.limit_channel  = LIM_RED;
      c.limit_scale    = '0;
      c.weight_red     = 14'd1;
      c.weight_green   = '0;
      c.weight_blue    = 14'h3FFF;
      apply_settings(c);
      queue_directed_pixels();
      wait_until_drained();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         apply_settings(random_settings());
         if (phase == RANDOM_PHASES - 1) begin
            quiet = 1'b1;
         end
         for (int n = 0; n < PHASE_PIXELS; n++) begin
            pixels_to_send.push_back(random_pixel());
         end
         wait_until_drained();
      end

      $display("Checked %0d pixels under %0d register settings.", pixels_checked,
               settings_applied + 1);
      $display("Settings spanned every spill channel, both limit modes, the alpha limit, "
               , "unit and user weights and the gain extremes.");
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
